// ===== hw/rtl/barometric_pressure_compensation_core_macros.svh =====
// assertion macros for the core rtl
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_CORE_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_CORE_MACROS_SVH

// same-cycle implication
`define BPC_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bpc assertion failed");

// next-cycle implication
`define BPC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bpc assertion failed");

`endif

// ===== hw/rtl/bpc_pkg.sv =====
package bpc_pkg;

   // calibration words unpacked from the registers
   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } calib_type;

   // one lane of the divider chain
   typedef struct packed {
      logic        valid;
      logic [63:0] rem;
      logic [63:0] nq;
      logic [63:0] den;
      logic        neg;
      logic        dz;
   } div_lane_type;

   // register indexes
   typedef enum logic [1:0] {
      CSR_TEMP_CAL   = 2'd0,
      CSR_PRESS_CALA = 2'd1,
      CSR_PRESS_CALB = 2'd2,
      CSR_PRESS_CALC = 2'd3
   } csr_index_type;

   localparam int          DIV_CELLS   = 64;
   localparam logic signed [31:0] TEMP_OFFSET = 32'sd128000;
   localparam logic [20:0] PRESS_BIAS  = 21'd1048576;
   localparam logic signed [63:0] DIV_SCALE   = 64'sd3125;
   localparam logic signed [63:0] ROUND_BIAS  = 64'sh0000_8000_0000_0000;

endpackage

// ===== hw/rtl/bpc_if.sv =====
interface bpc_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temperature;
   logic [19:0] adc_pressure;
   modport source (output valid, raw_temperature, adc_pressure, input ready);
   modport sink (input valid, raw_temperature, adc_pressure, output ready);
endinterface

interface bpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pressure_q24_8;
   logic        result_valid;
   modport source (output valid, pressure_q24_8, result_valid, input ready);
   modport sink (input valid, pressure_q24_8, result_valid, output ready);
endinterface

// ===== hw/rtl/bpc_front.sv =====
module bpc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [19:0]           raw_temperature,
   input  logic [19:0]           adc_pressure,
   input  bpc_pkg::calib_type    cal,
   output bpc_pkg::div_lane_type lane_out
);

   logic [9:0] v_ff;

   logic signed [17:0] a1_in, a1_ff, b1_in, b1_ff;
   logic [19:0]        rp1_ff, rp2_ff, rp3_ff, rp4_ff, rp5_ff, rp6_ff, rp7_ff;
   logic signed [33:0] at2_in, at2_ff;
   logic signed [35:0] bb_in, bb_ff;
   logic signed [22:0] v1_in, v1_ff;
   logic signed [23:0] bbs;
   logic signed [39:0] bt3_in, bt3_ff;
   logic signed [31:0] x4_in, x4_ff;
   logic signed [63:0] xx_in, xx_ff;
   logic signed [47:0] xp5_in, xp5_ff, xp2_in, xp2_ff, xp2b_ff;
   logic signed [63:0] y6_in, y6_ff, t6_in, t6_ff;
   logic signed [63:0] u7_in, u7_ff, y7_ff;
   logic signed [63:0] prod_in, prod_ff, n0_in, n0_ff;
   logic [20:0]        pdiff;
   logic signed [63:0] den_in, den_ff, num_in, num_ff;
   logic [63:0]        an, ad;
   logic [63:0]        nq_ff, dmag_ff;
   logic               neg_ff, dz_ff;

   // temperature terms
   always_comb begin
      a1_in  = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
      b1_in  = $signed({2'b0, raw_temperature[19:4]}) - $signed({2'b0, cal.t1});
      at2_in = 34'(a1_ff) * 34'(cal.t2);
      bb_in  = 36'(b1_ff) * 36'(b1_ff);
      v1_in  = 23'(at2_ff >>> 11);
      bbs    = 24'(bb_ff >>> 12);
      bt3_in = 40'(bbs) * 40'(cal.t3);
      x4_in  = 32'(v1_ff) + 32'(bt3_ff >>> 14) - bpc_pkg::TEMP_OFFSET;
   end

   // pressure terms up to the divider operands
   always_comb begin
      xx_in   = 64'(x4_ff) * 64'(x4_ff);
      xp5_in  = 48'(x4_ff) * 48'(cal.p5);
      xp2_in  = 48'(x4_ff) * 48'(cal.p2);
      y6_in   = (xx_ff * 64'(cal.p6)) + (64'(xp5_ff) <<< 17) + (64'(cal.p4) <<< 35);
      t6_in   = xx_ff * 64'(cal.p3);
      u7_in   = bpc_pkg::ROUND_BIAS + (t6_ff >>> 8) + (64'(xp2b_ff) <<< 12);
      prod_in = u7_ff * $signed({48'b0, cal.p1});
      pdiff   = bpc_pkg::PRESS_BIAS - {1'b0, rp7_ff};
      n0_in   = $signed({43'b0, pdiff} << 31) - y7_ff;
      den_in  = prod_ff >>> 33;
      num_in  = n0_ff * bpc_pkg::DIV_SCALE;
      an      = num_ff[63] ? 64'(-num_ff) : num_ff;
      ad      = den_ff[63] ? 64'(-den_ff) : den_ff;
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[8:0], in_valid};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff   <= a1_in;
         b1_ff   <= b1_in;
         rp1_ff  <= adc_pressure;
         at2_ff  <= at2_in;
         bb_ff   <= bb_in;
         rp2_ff  <= rp1_ff;
         v1_ff   <= v1_in;
         bt3_ff  <= bt3_in;
         rp3_ff  <= rp2_ff;
         x4_ff   <= x4_in;
         rp4_ff  <= rp3_ff;
         xx_ff   <= xx_in;
         xp5_ff  <= xp5_in;
         xp2_ff  <= xp2_in;
         rp5_ff  <= rp4_ff;
         y6_ff   <= y6_in;
         t6_ff   <= t6_in;
         xp2b_ff <= xp2_ff;
         rp6_ff  <= rp5_ff;
         u7_ff   <= u7_in;
         y7_ff   <= y6_ff;
         rp7_ff  <= rp6_ff;
         prod_ff <= prod_in;
         n0_ff   <= n0_in;
         den_ff  <= den_in;
         num_ff  <= num_in;
         nq_ff   <= an;
         dmag_ff <= ad;
         neg_ff  <= num_ff[63] ^ den_ff[63];
         dz_ff   <= (den_ff == '0);
      end
   end

   assign lane_out = '{valid: v_ff[9], rem: '0, nq: nq_ff, den: dmag_ff,
                       neg: neg_ff, dz: dz_ff};

endmodule

// ===== hw/rtl/bpc_div_cell.sv =====
module bpc_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  bpc_pkg::div_lane_type lane_in,
   output bpc_pkg::div_lane_type lane_out
);

   logic        valid_ff;
   logic [64:0] trial;
   logic [64:0] diff;
   logic        ge;
   logic [63:0] rem_in, rem_ff, nq_in, nq_ff, den_ff;
   logic        neg_ff, dz_ff;

   // one restoring step: bring down a numerator bit, subtract if it fits
   always_comb begin
      trial  = {lane_in.rem, lane_in.nq[63]};
      diff   = trial - {1'b0, lane_in.den};
      ge     = !diff[64];
      rem_in = ge ? diff[63:0] : trial[63:0];
      nq_in  = {lane_in.nq[62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= lane_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         nq_ff  <= nq_in;
         den_ff <= lane_in.den;
         neg_ff <= lane_in.neg;
         dz_ff  <= lane_in.dz;
      end
   end

   assign lane_out = '{valid: valid_ff, rem: rem_ff, nq: nq_ff, den: den_ff,
                       neg: neg_ff, dz: dz_ff};

endmodule

// ===== hw/rtl/bpc_back.sv =====
module bpc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  bpc_pkg::div_lane_type lane_in,
   input  bpc_pkg::calib_type    cal,
   output logic                  out_valid,
   output logic                  out_dz,
   output logic signed [63:0]    out_value
);

   logic [4:0] v_ff;
   logic [4:0] dz_ff;

   logic signed [63:0] p1_in, p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [63:0] s2_in, s2_ff, m2_in, m2_ff, y2_in, y2_ff, y3_ff, y4_ff;
   logic [63:0]        pp0_in, pp0_ff;
   logic [31:0]        pp1_in, pp1_ff, pp2_in, pp2_ff;
   logic [63:0]        mm_in, mm_ff;
   logic signed [63:0] f_in, f_ff;

   // signed quotient, then the second-order correction terms
   always_comb begin
      p1_in  = lane_in.neg ? $signed(64'(-lane_in.nq)) : $signed(lane_in.nq);
      s2_in  = p1_ff >>> 13;
      m2_in  = 64'(cal.p9) * s2_in;
      y2_in  = 64'(cal.p8) * p1_ff;
      pp0_in = {32'b0, m2_ff[31:0]} * {32'b0, s2_ff[31:0]};
      pp1_in = m2_ff[31:0] * s2_ff[63:32];
      pp2_in = m2_ff[63:32] * s2_ff[31:0];
      mm_in  = pp0_ff + {pp1_ff + pp2_ff, 32'b0};
      f_in   = ((p4_ff + ($signed(mm_ff) >>> 25) + (y4_ff >>> 19)) >>> 8)
               + (64'(cal.p7) <<< 4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], lane_in.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dz_ff  <= {dz_ff[3:0], lane_in.dz};
         p1_ff  <= p1_in;
         s2_ff  <= s2_in;
         m2_ff  <= m2_in;
         y2_ff  <= y2_in;
         p2_ff  <= p1_ff;
         pp0_ff <= pp0_in;
         pp1_ff <= pp1_in;
         pp2_ff <= pp2_in;
         y3_ff  <= y2_ff;
         p3_ff  <= p2_ff;
         mm_ff  <= mm_in;
         y4_ff  <= y3_ff;
         p4_ff  <= p3_ff;
         f_ff   <= f_in;
      end
   end

   assign out_valid = v_ff[4];
   assign out_dz    = dz_ff[4];
   assign out_value = f_ff;

endmodule

// ===== hw/rtl/barometric_pressure_compensation_core.sv =====
// path: an accepted item runs through the front stages, the divider chain and the back stages to the output register
// throughput: one item per cycle while the output is not stalled; the 64-cell divider chain retires one
//    quotient bit per cell and every stage advances together
// a stalled output holds the whole pipeline until the result is taken
// reset: synchronous, clears all stage valids and the calibration registers
`include "barometric_pressure_compensation_core_macros.svh"

module barometric_pressure_compensation_core (
   input  logic             clock,
   input  logic             reset,
   bpc_req_if.sink          req_ch,
   bpc_rsp_if.source        rsp_ch,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_write_data
);

   logic [47:0] temp_cal_ff;
   logic [63:0] press_cala_ff, press_calb_ff;
   logic [15:0] press_calc_ff;

   bpc_pkg::calib_type cal;
   logic en;

   bpc_pkg::div_lane_type lane [bpc_pkg::DIV_CELLS + 1];

   logic               back_valid, back_dz;
   logic signed [63:0] back_value;

   logic        out_valid_ff;
   logic [31:0] out_press_in, out_press_ff;
   logic        out_rv_ff;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff   <= '0;
         press_cala_ff <= '0;
         press_calb_ff <= '0;
         press_calc_ff <= '0;
      end else if (csr_write_enable) begin
         case (bpc_pkg::csr_index_type'(csr_index))
            bpc_pkg::CSR_TEMP_CAL:   temp_cal_ff   <= csr_write_data[47:0];
            bpc_pkg::CSR_PRESS_CALA: press_cala_ff <= csr_write_data;
            bpc_pkg::CSR_PRESS_CALB: press_calb_ff <= csr_write_data;
            bpc_pkg::CSR_PRESS_CALC: press_calc_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // calibration word unpacking
   always_comb begin
      cal.t1 = temp_cal_ff[15:0];
      cal.t2 = temp_cal_ff[31:16];
      cal.t3 = temp_cal_ff[47:32];
      cal.p1 = press_cala_ff[15:0];
      cal.p2 = press_cala_ff[31:16];
      cal.p3 = press_cala_ff[47:32];
      cal.p4 = press_cala_ff[63:48];
      cal.p5 = press_calb_ff[15:0];
      cal.p6 = press_calb_ff[31:16];
      cal.p7 = press_calb_ff[47:32];
      cal.p8 = press_calb_ff[63:48];
      cal.p9 = press_calc_ff;
   end

   // whole pipeline moves when the output register is free or being emptied
   assign en           = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   bpc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (req_ch.valid),
      .raw_temperature (req_ch.raw_temperature),
      .adc_pressure    (req_ch.adc_pressure),
      .cal             (cal),
      .lane_out        (lane[0])
   );

   // divider chain, one quotient bit per cell
   for (genvar i = 0; i < bpc_pkg::DIV_CELLS; i++) begin : g_div
      bpc_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .lane_in  (lane[i]),
         .lane_out (lane[i + 1])
      );
   end

   bpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .lane_in   (lane[bpc_pkg::DIV_CELLS]),
      .cal       (cal),
      .out_valid (back_valid),
      .out_dz    (back_dz),
      .out_value (back_value)
   );

   // saturation into the output register
   always_comb begin
      if (back_dz || back_value[63]) begin
         out_press_in = '0;
      end else if (back_value[62:32] != '0) begin
         out_press_in = '1;
      end else begin
         out_press_in = back_value[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= back_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_press_ff <= out_press_in;
         out_rv_ff    <= !back_dz;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.pressure_q24_8 = out_press_ff;
   assign rsp_ch.result_valid   = out_rv_ff;

   // checks
   `BPC_ASSERT_IMPLY(a_stall_blocks_input, clock, reset, out_valid_ff && !rsp_ch.ready, !en)
   `BPC_ASSERT_IMPLY(a_invalid_is_zero, clock, reset, out_valid_ff && !out_rv_ff, out_press_ff == '0)
   `BPC_ASSERT_NEXT(a_result_loaded, clock, reset, en && back_valid, out_valid_ff)

endmodule

// ===== bench/barometric_pressure_compensation_core_tb.sv =====
`timescale 1ns / 100ps

module barometric_pressure_compensation_core_tb;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;

   bpc_req_if req_ch ();
   bpc_rsp_if rsp_ch ();

   barometric_pressure_compensation_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch.sink),
      .rsp_ch           (rsp_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   typedef struct packed {
      logic [31:0] pressure;
      logic        flag;
   } pressure_result_type;

   typedef struct {
      logic [19:0] raw_t;
      logic [19:0] raw_p;
      bit          typed;
      logic [31:0] pressure;
      logic        flag;
   } sample_row_type;

   // calibration shadow
   logic [47:0] cal_temp;
   logic [63:0] cal_press_a;
   logic [63:0] cal_press_b;
   logic [15:0] cal_press_c;

   pressure_result_type expected_pressures[$];
   bit     failed;
   bit     stimulus_done;
   int     results_taken;
   sample_row_type sample_rows[$];

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [63:0] sx16(logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] asr(logic [63:0] x, int n);
      logic signed [63:0] s;
      s = x;
      return s >>> n;
   endfunction

   // integer compensation: fine temperature, then pressure in pa * 256
   function automatic pressure_result_type compensate_pressure(logic [19:0] raw_t,
                                                               logic [19:0] raw_p);
      logic [63:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] a, b, v1, v2, fine, x, y, p;
      logic signed [63:0] num, den, quo;
      pressure_result_type r;
      adc_t = {44'd0, raw_t};
      adc_p = {44'd0, raw_p};
      t1 = {48'd0, cal_temp[15:0]};
      t2 = sx16(cal_temp[31:16]);
      t3 = sx16(cal_temp[47:32]);
      p1 = {48'd0, cal_press_a[15:0]};
      p2 = sx16(cal_press_a[31:16]);
      p3 = sx16(cal_press_a[47:32]);
      p4 = sx16(cal_press_a[63:48]);
      p5 = sx16(cal_press_b[15:0]);
      p6 = sx16(cal_press_b[31:16]);
      p7 = sx16(cal_press_b[47:32]);
      p8 = sx16(cal_press_b[63:48]);
      p9 = sx16(cal_press_c);
      // temperature
      a = (adc_t >> 3) - (t1 << 1);
      v1 = asr(a * t2, 11);
      b = (adc_t >> 4) - t1;
      v2 = asr(asr(b * b, 12) * t3, 14);
      fine = v1 + v2;
      // pressure
      x = fine - 64'd128000;
      y = x * x * p6;
      y = y + ((x * p5) << 17);
      y = y + (p4 << 35);
      x = asr(x * x * p3, 8) + ((x * p2) << 12);
      x = asr(((64'd1 << 47) + x) * p1, 33);
      if (x == 64'd0) begin
         r.pressure = '0;
         r.flag = 1'b0;
         return r;
      end
      p = 64'd1048576 - adc_p;
      num = ((p << 31) - y) * 64'd3125;
      den = x;
      // the one overflowing quotient keeps the numerator
      if (num == {1'b1, 63'd0} && den == -64'sd1) quo = num;
      else quo = num / den;
      p = quo;
      x = asr(p9 * asr(p, 13) * asr(p, 13), 25);
      y = asr(p8 * p, 19);
      p = asr(p + x + y, 8) + (p7 << 4);
      // saturate to the unsigned output range
      if (p[63]) r.pressure = '0;
      else if (p > 64'hFFFF_FFFF) r.pressure = 32'hFFFF_FFFF;
      else r.pressure = p[31:0];
      r.flag = 1'b1;
      return r;
   endfunction

   // the caller drops the write enable after its last write
   task automatic write_register(bpc_pkg::csr_index_type idx, logic [63:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         bpc_pkg::CSR_TEMP_CAL: begin
            cal_temp = value[47:0];
         end
         bpc_pkg::CSR_PRESS_CALA: begin
            cal_press_a = value;
         end
         bpc_pkg::CSR_PRESS_CALB: begin
            cal_press_b = value;
         end
         bpc_pkg::CSR_PRESS_CALC: begin
            cal_press_c = value[15:0];
         end
         default: ;
      endcase
   endtask

   task automatic load_calibration(logic [63:0] tc, logic [63:0] pa, logic [63:0] pb,
                                   logic [63:0] pc);
      write_register(bpc_pkg::CSR_TEMP_CAL, tc);
      write_register(bpc_pkg::CSR_PRESS_CALA, pa);
      write_register(bpc_pkg::CSR_PRESS_CALB, pb);
      write_register(bpc_pkg::CSR_PRESS_CALC, pc);
      csr_write_enable <= 1'b0;
   endtask

   // offer one item, wait for acceptance, record its expected result
   task automatic send_sample(sample_row_type row);
      int gap;
      pressure_result_type r;
      gap = $urandom_range(0, 11);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.raw_temperature <= row.raw_t;
      req_ch.adc_pressure <= row.raw_p;
      do @(posedge clock); while (!req_ch.ready);
      if (row.typed) begin
         r.pressure = row.pressure;
         r.flag = row.flag;
      end else begin
         r = compensate_pressure(row.raw_t, row.raw_p);
      end
      expected_pressures.push_back(r);
   endtask

   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      while (expected_pressures.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [19:0] random_raw(logic [19:0] centre);
      case ($urandom_range(0, 3))
         0: return 20'($urandom_range(0, 20'hFFFFF));
         1: return $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
         default: return 20'(centre + $urandom_range(0, 16383) - 20'd8192);
      endcase
   endfunction

   // stimulus
   initial begin
      sample_row_type row;
      logic [63:0] typ_tc, typ_pa, typ_pb, typ_pc;
      logic [63:0] tc, pa, pb, pc;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.raw_temperature = '0;
      req_ch.adc_pressure = '0;
      cal_temp = '0;
      cal_press_a = '0;
      cal_press_b = '0;
      cal_press_c = '0;
      failed = 1'b0;
      stimulus_done = 1'b0;
      typ_tc = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
      typ_pa = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
      typ_pb = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
      typ_pc = 64'd6000;

      // after reset p1 is zero, so every item comes back invalid
      sample_rows.push_back('{20'h00000, 20'h00000, 1'b1, 32'd0, 1'b0});
      sample_rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b1, 32'd0, 1'b0});
      sample_rows.push_back('{20'h00000, 20'hFFFFF, 1'b1, 32'd0, 1'b0});
      sample_rows.push_back('{20'hFFFFF, 20'h00000, 1'b1, 32'd0, 1'b0});
      sample_rows.push_back('{20'd519888, 20'd415148, 1'b1, 32'd0, 1'b0});
      // typical calibration rows, checked by the predictor
      sample_rows.push_back('{20'd519888, 20'd415148, 1'b0, '0, 1'b0});
      sample_rows.push_back('{20'h00000, 20'h00000, 1'b0, '0, 1'b0});
      sample_rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b0, '0, 1'b0});
      sample_rows.push_back('{20'h00000, 20'hFFFFF, 1'b0, '0, 1'b0});
      sample_rows.push_back('{20'hFFFFF, 20'h00000, 1'b0, '0, 1'b0});
      sample_rows.push_back('{20'h80000, 20'h80000, 1'b0, '0, 1'b0});
      sample_rows.push_back('{20'h55555, 20'hAAAAA, 1'b0, '0, 1'b0});
      sample_rows.push_back('{20'hAAAAA, 20'h55555, 1'b0, '0, 1'b0});
      sample_rows.push_back('{20'd519888, 20'd0, 1'b0, '0, 1'b0});
      sample_rows.push_back('{20'd519888, 20'hFFFFF, 1'b0, '0, 1'b0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items
      foreach (sample_rows[i]) begin
         if (i == 5) begin
            drain_pipeline();
            load_calibration(typ_tc, typ_pa, typ_pb, typ_pc);
         end
         send_sample(sample_rows[i]);
      end

      // random phases over several calibration settings
      for (int ph = 0; ph < 9; ph++) begin
         drain_pipeline();
         case (ph)
            0: begin
               tc = typ_tc; pa = typ_pa; pb = typ_pb; pc = typ_pc;
            end
            1: begin
               // all ones, with bits above the widths of the temperature and third pressure registers
               tc = '1; pa = '1; pb = '1; pc = '1;
            end
            2: begin
               // signed words at their most negative, t1 at zero and p1 at one
               tc = {16'h8000, 16'h8000, 16'h8000, 16'h0000};
               pa = {16'h8000, 16'h8000, 16'h8000, 16'h0001};
               pb = {4{16'h8000}};
               pc = 64'h8000;
            end
            3: begin
               // zero divisor
               tc = typ_tc; pa = {typ_pa[63:16], 16'd0}; pb = typ_pb; pc = typ_pc;
            end
            4, 5: begin
               tc = {$urandom, $urandom}; pa = {$urandom, $urandom};
               pb = {$urandom, $urandom}; pc = {$urandom, $urandom};
            end
            6: begin
               tc = {16'd0, 16'h7FFF, 16'h7FFF, 16'hFFFF};
               pa = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
               pb = {4{16'h7FFF}};
               pc = 64'h7FFF;
            end
            default: begin
               tc = typ_tc ^ {$urandom_range(0, 255), 32'd0};
               pa = typ_pa ^ {$urandom_range(0, 255), 32'd0};
               pb = typ_pb ^ {$urandom_range(0, 255), 32'd0};
               pc = typ_pc ^ 64'($urandom_range(0, 63));
            end
         endcase
         load_calibration(tc, pa, pb, pc);
         for (int n = 0; n < 128; n++) begin
            row.raw_t = random_raw(20'd519888);
            row.raw_p = random_raw(20'd415148);
            row.typed = 1'b0;
            row.pressure = '0;
            row.flag = 1'b0;
            send_sample(row);
         end
      end
      req_ch.valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // result side: random stalls and one long hold-off
   initial begin
      int stall;
      pressure_result_type e;
      rsp_ch.ready = 1'b0;
      results_taken = 0;
      @(negedge reset);
      forever begin
         stall = (results_taken == 300) ? 400 : $urandom_range(0, 11);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         results_taken++;
         if (expected_pressures.size() == 0) begin
            $error("unexpected item: pressure_q24_8 %0h result_valid %0b",
                   rsp_ch.pressure_q24_8, rsp_ch.result_valid);
            failed = 1'b1;
         end else begin
            e = expected_pressures.pop_front();
            if (rsp_ch.pressure_q24_8 !== e.pressure) begin
               $error("pressure_q24_8 expected %0h actual %0h", e.pressure,
                      rsp_ch.pressure_q24_8);
               failed = 1'b1;
            end
            if (rsp_ch.result_valid !== e.flag) begin
               $error("result_valid expected %0b actual %0b", e.flag,
                      rsp_ch.result_valid);
               failed = 1'b1;
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stimulus_done);
      while (expected_pressures.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (!failed) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_if.sv
hw/rtl/bpc_front.sv
hw/rtl/bpc_div_cell.sv
hw/rtl/bpc_back.sv
hw/rtl/barometric_pressure_compensation_core.sv
bench/barometric_pressure_compensation_core_tb.sv
